FILE: src/gps_pkg.sv
package gps_pkg;

    // widths of the request and result fields
    localparam int ValueW = 16;
    localparam int CountW = 2;

    // default sieve depth, one mark per integer
    localparam int SieveSizeDef = 65536;

    // width that holds any sieve size in its range (up to 2**20)
    localparam int RangeW = 21;

    // small primes and values handled without a search
    localparam logic [ValueW-1:0] Prime2 = ValueW'(2);
    localparam logic [ValueW-1:0] Prime3 = ValueW'(3);
    localparam logic [ValueW-1:0] Four   = ValueW'(4);

endpackage

FILE: src/gps_sieve_mem.sv
module gps_sieve_mem import gps_pkg::*; #(
    parameter int SieveSize = SieveSizeDef,
    parameter int AddrW     = $clog2(SieveSize)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic             i_wr_data,
    input  logic [AddrW-1:0] i_rd_addr_a,
    input  logic [AddrW-1:0] i_rd_addr_b,
    output logic             o_rd_data_a,
    output logic             o_rd_data_b
);

    // prime marks, one bit per integer
    logic r_mem [SieveSize];
    logic r_rd_a;
    logic r_rd_b;

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

FILE: src/gps_sieve_builder.sv
module gps_sieve_builder import gps_pkg::*; #(
    parameter int SieveSize = SieveSizeDef,
    parameter int AddrW     = $clog2(SieveSize),
    parameter int CntW      = $clog2(SieveSize + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_wr_en,
    output logic [AddrW-1:0] o_wr_addr,
    output logic             o_wr_data,
    output logic [AddrW-1:0] o_rd_addr,
    input  logic             i_rd_data,
    output logic             o_done
);

    typedef enum logic [4:0] {
        S_FILL = 5'b00001,
        S_READ = 5'b00010,
        S_TEST = 5'b00100,
        S_MARK = 5'b01000,
        S_DONE = 5'b10000
    } t_bld_state;

    localparam logic [CntW:0] Limit = (CntW + 1)'(SieveSize);
    localparam logic [CntW-1:0] LastAddr = CntW'(SieveSize - 1);

    t_bld_state    r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;   // fill address, then the current base i
    logic [CntW-1:0] r_sq, n_sq;     // i*i, kept by increments
    logic [CntW-1:0] r_j, n_j;       // multiple being struck out
    logic [CntW:0]   w_jsum;
    logic [CntW:0]   w_sqsum;

    assign w_jsum  = {1'b0, r_j} + {1'b0, r_cnt};
    assign w_sqsum = {1'b0, r_sq} + {r_cnt, 1'b1};

    // memory ports
    assign o_wr_en   = (r_state == S_FILL) || (r_state == S_MARK);
    assign o_wr_addr = (r_state == S_FILL) ? AddrW'(r_cnt) : AddrW'(r_j);
    assign o_wr_data = (r_state == S_FILL) && (r_cnt >= CntW'(2));
    assign o_rd_addr = AddrW'(r_cnt);
    assign o_done    = (r_state == S_DONE);

    // sequencer: fill, then strike multiples of each prime base
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sq    = r_sq;
        n_j     = r_j;
        case (r_state)
            S_FILL: begin
                if (r_cnt == LastAddr) begin
                    n_cnt   = CntW'(2);
                    n_sq    = CntW'(4);
                    n_state = S_READ;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            S_READ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_rd_data) begin
                    n_j     = r_sq;
                    n_state = S_MARK;
                end else begin
                    n_cnt   = r_cnt + CntW'(1);
                    n_sq    = CntW'(w_sqsum);
                    n_state = (w_sqsum >= Limit) ? S_DONE : S_READ;
                end
            end
            S_MARK: begin
                if (w_jsum >= Limit) begin
                    n_cnt   = r_cnt + CntW'(1);
                    n_sq    = CntW'(w_sqsum);
                    n_state = (w_sqsum >= Limit) ? S_DONE : S_READ;
                end else begin
                    n_j = CntW'(w_jsum);
                end
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_sq <= n_sq;
        r_j  <= n_j;
    end

endmodule

FILE: src/gps_search.sv
module gps_search import gps_pkg::*; #(
    parameter int SieveSize = SieveSizeDef,
    parameter int AddrW     = $clog2(SieveSize)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sieve_done,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ValueW-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CountW-1:0] o_count,
    output logic [ValueW-1:0] o_first_prime,
    output logic [ValueW-1:0] o_second_prime,
    output logic [ValueW-1:0] o_third_prime,
    output logic [AddrW-1:0]  o_rd_addr_a,
    output logic [AddrW-1:0]  o_rd_addr_b,
    input  logic              i_rd_data_a,
    input  logic              i_rd_data_b
);

    typedef enum logic [4:0] {
        S_WAIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_srch_state;

    localparam logic [RangeW-1:0] SizeLim = RangeW'(SieveSize);

    t_srch_state       r_state, n_state;
    logic              r_odd, n_odd;          // result opens with 3
    logic [ValueW-1:0] r_p, n_p;              // low candidate
    logic [ValueW-1:0] r_q, n_q;              // partner, m - p
    logic              r_p_ok, n_p_ok;
    logic              r_q_ok, n_q_ok;
    logic [CountW-1:0] r_cnt, n_cnt;
    logic [ValueW-1:0] r_f1, n_f1;
    logic [ValueW-1:0] r_f2, n_f2;
    logic [ValueW-1:0] r_f3, n_f3;
    logic              r_o_valid, n_o_valid;
    logic [CountW-1:0] r_o_count, n_o_count;
    logic [ValueW-1:0] r_o_f1, n_o_f1;
    logic [ValueW-1:0] r_o_f2, n_o_f2;
    logic [ValueW-1:0] r_o_f3, n_o_f3;

    logic              w_odd;
    logic [ValueW-1:0] w_m;
    logic              w_p_in;
    logic              w_q_in;
    logic              w_hit;
    logic [ValueW-1:0] w_p_next;
    logic [ValueW-1:0] w_q_next;

    // odd values peel off a leading 3
    assign w_odd = i_value[0] && (i_value >= Prime3);
    assign w_m   = w_odd ? (i_value - Prime3) : i_value;

    // candidates beyond the sieve count as composite
    assign w_p_in = {(RangeW - ValueW)'(0), r_p} < SizeLim;
    assign w_q_in = {(RangeW - ValueW)'(0), r_q} < SizeLim;
    assign o_rd_addr_a = w_p_in ? AddrW'(r_p) : '0;
    assign o_rd_addr_b = w_q_in ? AddrW'(r_q) : '0;

    assign w_hit    = r_p_ok && i_rd_data_a && r_q_ok && i_rd_data_b;
    assign w_p_next = r_p + Prime2;
    assign w_q_next = r_q - Prime2;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_count        = r_o_count;
    assign o_first_prime  = r_o_f1;
    assign o_second_prime = r_o_f2;
    assign o_third_prime  = r_o_f3;

    // request decode, odd-candidate walk, result hand-off
    always_comb begin
        n_state   = r_state;
        n_odd     = r_odd;
        n_p       = r_p;
        n_q       = r_q;
        n_p_ok    = r_p_ok;
        n_q_ok    = r_q_ok;
        n_cnt     = r_cnt;
        n_f1      = r_f1;
        n_f2      = r_f2;
        n_f3      = r_f3;
        n_o_valid = r_o_valid && i_out_stall;
        n_o_count = r_o_count;
        n_o_f1    = r_o_f1;
        n_o_f2    = r_o_f2;
        n_o_f3    = r_o_f3;
        case (r_state)
            S_WAIT: begin
                if (i_sieve_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_odd = w_odd;
                    n_f1  = w_odd ? Prime3 : '0;
                    n_f2  = '0;
                    n_f3  = '0;
                    n_cnt = w_odd ? CountW'(1) : CountW'(0);
                    n_state = S_DONE;
                    if (w_m <= ValueW'(1)) begin
                        // nothing more to add
                    end else if (w_m == Prime2) begin
                        if (w_odd) begin
                            n_f2  = Prime2;
                            n_cnt = CountW'(2);
                        end else begin
                            n_f1  = Prime2;
                            n_cnt = CountW'(1);
                        end
                    end else if (w_m == Four) begin
                        if (w_odd) begin
                            n_f2  = Prime2;
                            n_f3  = Prime2;
                            n_cnt = CountW'(3);
                        end else begin
                            n_f1  = Prime2;
                            n_f2  = Prime2;
                            n_cnt = CountW'(2);
                        end
                    end else begin
                        // even m >= 6: p = 2 never pairs, walk odd p
                        n_p     = Prime3;
                        n_q     = w_m - Prime3;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_p_ok  = w_p_in;
                n_q_ok  = w_q_in;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_hit) begin
                    n_state = S_DONE;
                    if (r_odd) begin
                        n_f1  = Prime3;
                        n_f2  = r_p;
                        n_f3  = r_q;
                        n_cnt = CountW'(3);
                    end else begin
                        n_f1  = r_p;
                        n_f2  = r_q;
                        n_f3  = '0;
                        n_cnt = CountW'(2);
                    end
                end else if (w_p_next > w_q_next) begin
                    // search exhausted: empty result
                    n_state = S_DONE;
                    n_f1    = '0;
                    n_f2    = '0;
                    n_f3    = '0;
                    n_cnt   = '0;
                end else begin
                    n_p     = w_p_next;
                    n_q     = w_q_next;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid = 1'b1;
                    n_o_count = r_cnt;
                    n_o_f1    = r_f1;
                    n_o_f2    = r_f2;
                    n_o_f3    = r_f3;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_WAIT;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_odd     <= n_odd;
        r_p       <= n_p;
        r_q       <= n_q;
        r_p_ok    <= n_p_ok;
        r_q_ok    <= n_q_ok;
        r_cnt     <= n_cnt;
        r_f1      <= n_f1;
        r_f2      <= n_f2;
        r_f3      <= n_f3;
        r_o_count <= n_o_count;
        r_o_f1    <= n_o_f1;
        r_o_f2    <= n_o_f2;
        r_o_f3    <= n_o_f3;
    end

endmodule

FILE: src/goldbach_prime_splitter_unit.sv
// Channel  Direction  Handshake                 Payload
// in       request    i_in_valid / o_in_stall   i_value
// out      result     o_out_valid / i_out_stall o_count, o_first_prime,
//                                               o_second_prime, o_third_prime
//
// After reset the sieve is built in the mark memory: a fill of every address, then
// multiples of each prime base struck out; no request is taken until it ends.
// A request needing no search goes from idle to done, where its result is loaded;
// otherwise the odd candidates are tried in turn, one memory read each.
// A held result blocks only the hand-off of the next one, with the input stalled.
module goldbach_prime_splitter_unit import gps_pkg::*; #(
    parameter int SIEVE_SIZE = SieveSizeDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ValueW-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CountW-1:0] o_count,
    output logic [ValueW-1:0] o_first_prime,
    output logic [ValueW-1:0] o_second_prime,
    output logic [ValueW-1:0] o_third_prime
);

    localparam int AddrW = $clog2(SIEVE_SIZE);
    localparam int CntW  = $clog2(SIEVE_SIZE + 1);

    logic             w_wr_en;
    logic [AddrW-1:0] w_wr_addr;
    logic             w_wr_data;
    logic [AddrW-1:0] w_bld_rd_addr;
    logic [AddrW-1:0] w_srch_rd_addr_a;
    logic [AddrW-1:0] w_rd_addr_a;
    logic [AddrW-1:0] w_rd_addr_b;
    logic             w_rd_data_a;
    logic             w_rd_data_b;
    logic             w_sieve_done;

    // read port A belongs to the builder until the sieve is done
    assign w_rd_addr_a = w_sieve_done ? w_srch_rd_addr_a : w_bld_rd_addr;

    gps_sieve_mem #(
        .SieveSize (SIEVE_SIZE),
        .AddrW     (AddrW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    gps_sieve_builder #(
        .SieveSize (SIEVE_SIZE),
        .AddrW     (AddrW),
        .CntW      (CntW)
    ) u_builder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_bld_rd_addr),
        .i_rd_data (w_rd_data_a),
        .o_done    (w_sieve_done)
    );

    gps_search #(
        .SieveSize (SIEVE_SIZE),
        .AddrW     (AddrW)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sieve_done   (w_sieve_done),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_count        (o_count),
        .o_first_prime  (o_first_prime),
        .o_second_prime (o_second_prime),
        .o_third_prime  (o_third_prime),
        .o_rd_addr_a    (w_srch_rd_addr_a),
        .o_rd_addr_b    (w_rd_addr_b),
        .i_rd_data_a    (w_rd_data_a),
        .i_rd_data_b    (w_rd_data_b)
    );

    // no request enters while the sieve is still being built
    a_no_req_before_sieve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_sieve_done |-> o_in_stall)
        else $error("request accepted before sieve complete");

    // the builder never writes once the sieve is finished
    a_no_write_after_sieve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sieve_done |-> !w_wr_en)
        else $error("sieve write after build complete");

    // a three-prime result always opens with 3
    a_triple_leads_3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_count == CountW'(3))) |-> (o_first_prime == Prime3))
        else $error("three-prime result without leading 3");

    // an empty result carries no primes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_count == CountW'(0))) |->
            (o_first_prime == '0 && o_second_prime == '0 && o_third_prime == '0))
        else $error("empty result with non-zero prime");

endmodule
